>>> rtl/mtid_pkg.sv
// Package for the address-to-id table: widths, status codes and controller states.
package mtid_pkg;

  localparam int unsigned TableEntriesDef = 8;
  localparam int unsigned MacW = 48;
  localparam int unsigned IdW = 8;
  localparam int unsigned StatusW = 3;

  typedef enum logic [StatusW-1:0] {
    StKnown    = 3'd0,
    StNew      = 3'd1,
    StFull     = 3'd2,
    StFound    = 3'd3,
    StNotFound = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SReadId
  } state_e;

endpackage

>>> rtl/mtid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mtid_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/mac_to_id_assignment_table.sv
// Top level of the address-to-id table: lookup-or-insert and read-by-id over one RAM.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   request  | start_i, busy_o      | req_type_i, mac_addr_i, query_id_i
//   result   | done_o (1-cycle)     | result_id_o, mac_out_o, status_o
//
// An assign request scans the RAM one entry per cycle (one RAM read per cycle, data
// registered) until a match or the last stored entry; an empty table answers at once.
// A by-id request reads the RAM when the id is stored and answers at once otherwise.
// Reset clears the state, entry count, scan index and done strobe; the RAM is never cleared.
// A request transfer happens when start_i is high and busy_o low; results are
// strobed for one cycle and cannot be stalled.
module mac_to_id_assignment_table #(
  parameter int unsigned TABLE_ENTRIES = mtid_pkg::TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          req_type_i,
  input  logic [mtid_pkg::MacW-1:0]     mac_addr_i,
  input  logic [mtid_pkg::IdW-1:0]      query_id_i,
  output logic                          done_o,
  output logic [mtid_pkg::IdW-1:0]      result_id_o,
  output logic [mtid_pkg::MacW-1:0]     mac_out_o,
  output logic [mtid_pkg::StatusW-1:0]  status_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  mtid_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            done_q, done_d;

  logic [mtid_pkg::MacW-1:0] mac_q, mac_d;
  logic [mtid_pkg::IdW-1:0]  res_id_q, res_id_d;
  logic [mtid_pkg::MacW-1:0] res_mac_q, res_mac_d;
  mtid_pkg::status_e         res_st_q, res_st_d;

  logic                      we;
  logic [IdxW-1:0]           waddr;
  logic [mtid_pkg::MacW-1:0] wdata;
  logic                      re;
  logic [IdxW-1:0]           raddr;
  logic [mtid_pkg::MacW-1:0] rdata;
  logic                      room;

  assign room = 32'(count_q) < TABLE_ENTRIES;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    mac_d     = mac_q;
    res_id_d  = res_id_q;
    res_mac_d = res_mac_q;
    res_st_d  = res_st_q;
    we        = 1'b0;
    waddr     = count_q[IdxW-1:0];
    wdata     = mac_q;
    re        = 1'b0;
    raddr     = idx_q;

    unique case (state_q)
      mtid_pkg::SIdle: begin
        if (start_i) begin
          mac_d = mac_addr_i;
          if (req_type_i) begin
            if (32'(query_id_i) < 32'(count_q)) begin
              re      = 1'b1;
              raddr   = query_id_i[IdxW-1:0];
              state_d = mtid_pkg::SReadId;
            end else begin
              done_d    = 1'b1;
              res_id_d  = '0;
              res_mac_d = '0;
              res_st_d  = mtid_pkg::StNotFound;
            end
          end else if (count_q == '0) begin
            we        = 1'b1;
            wdata     = mac_addr_i;
            count_d   = count_q + CntW'(1);
            done_d    = 1'b1;
            res_id_d  = '0;
            res_mac_d = '0;
            res_st_d  = mtid_pkg::StNew;
          end else begin
            re      = 1'b1;
            raddr   = '0;
            idx_d   = '0;
            state_d = mtid_pkg::SScan;
          end
        end
      end
      mtid_pkg::SScan: begin
        if (rdata == mac_q) begin
          done_d    = 1'b1;
          res_id_d  = mtid_pkg::IdW'(idx_q);
          res_mac_d = '0;
          res_st_d  = mtid_pkg::StKnown;
          state_d   = mtid_pkg::SIdle;
        end else if (CntW'(idx_q) + CntW'(1) == count_q) begin
          done_d    = 1'b1;
          res_mac_d = '0;
          state_d   = mtid_pkg::SIdle;
          if (room) begin
            we       = 1'b1;
            count_d  = count_q + CntW'(1);
            res_id_d = mtid_pkg::IdW'(count_q);
            res_st_d = mtid_pkg::StNew;
          end else begin
            res_id_d = '0;
            res_st_d = mtid_pkg::StFull;
          end
        end else begin
          re    = 1'b1;
          raddr = idx_q + IdxW'(1);
          idx_d = idx_q + IdxW'(1);
        end
      end
      mtid_pkg::SReadId: begin
        done_d    = 1'b1;
        res_id_d  = '0;
        res_mac_d = rdata;
        res_st_d  = mtid_pkg::StFound;
        state_d   = mtid_pkg::SIdle;
      end
      default: begin
        state_d = mtid_pkg::SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtid_pkg::SIdle;
      count_q <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mac_q     <= mac_d;
    res_id_q  <= res_id_d;
    res_mac_q <= res_mac_d;
    res_st_q  <= res_st_d;
  end

  mtid_ram #(
    .Width (mtid_pkg::MacW),
    .Depth (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy_o      = (state_q != mtid_pkg::SIdle);
  assign done_o      = done_q;
  assign result_id_o = res_id_q;
  assign mac_out_o   = res_mac_q;
  assign status_o    = res_st_q;

endmodule
